### sv/brl_pkg.sv
// Shared constants, types and register codes of the Bresenham line rasterizer.
`default_nettype none
package brl_pkg;

   localparam int COORD_BITS = 11;
   localparam int ERR_BITS   = COORD_BITS + 3;
   localparam int ADDR_BITS  = 2 * COORD_BITS;
   localparam int DIM_BITS   = 12;
   localparam int COLOR_BITS = 24;
   localparam int PROD_BITS  = DIM_BITS + COORD_BITS;
   localparam int SUM_BITS   = ((ADDR_BITS > PROD_BITS) ? ADDR_BITS : PROD_BITS) + 1;
   localparam int CMP_BITS   = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;

   localparam int REQ_DATA_BITS = ((4 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = 2 * COORD_BITS + ADDR_BITS + COLOR_BITS;
   localparam int RSP_DATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DRAW_COLOR   = 2'd2;

   localparam logic [DIM_BITS-1:0]   WIDTH_RESET  = 12'd1600;
   localparam logic [DIM_BITS-1:0]   HEIGHT_RESET = 12'd900;
   localparam logic [COLOR_BITS-1:0] COLOR_RESET  = 24'hFFC39F;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   typedef logic [COORD_BITS-1:0]        coord_type;
   typedef logic signed [COORD_BITS:0]   delta_type;
   typedef logic signed [ERR_BITS-1:0]   err_type;
   typedef logic [SUM_BITS-1:0]          sum_type;
   typedef logic [CMP_BITS-1:0]          cmp_type;
   typedef logic [REQ_DATA_BITS-1:0]     req_data_type;
   typedef logic [RSP_DATA_BITS-1:0]     rsp_data_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      logic      last;
   } pixel_type;

endpackage
`default_nettype wire

### sv/brl_walker.sv
// Line setup and Bresenham step logic with the walker state and pixel stage register.
`default_nettype none
module brl_walker (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 in_valid,
   output logic                in_ready,
   input  wire                 in_command,
   input  brl_pkg::coord_type  in_x_start,
   input  brl_pkg::coord_type  in_y_start,
   input  brl_pkg::coord_type  in_x_end,
   input  brl_pkg::coord_type  in_y_end,
   output logic                out_valid,
   input  wire                 out_ready,
   output brl_pkg::pixel_type  out_pixel
);

   brl_pkg::coord_type col_ff, row_ff, major_end_ff, adx_ff, ady_ff;
   brl_pkg::err_type   err_ff;
   logic               x_major_ff, minor_up_ff, active_ff;
   logic               s1_valid_ff;
   brl_pkg::pixel_type s1_pixel_ff;

   brl_pkg::delta_type dx, dy;
   brl_pkg::coord_type st_adx, st_ady, st_col, st_row, st_mend;
   logic               st_xmaj, st_up, st_neg;
   brl_pkg::err_type   st_err;

   brl_pkg::coord_type sp_col, sp_row;
   brl_pkg::err_type   sp_err, two_adx, two_ady;

   brl_pkg::coord_type col_in, row_in, major_end_in, adx_in, ady_in;
   brl_pkg::err_type   err_in;
   logic               x_major_in, minor_up_in;
   logic               is_start, accept, emit, fin;

   assign in_ready = !s1_valid_ff || out_ready;
   assign accept   = in_valid && in_ready;
   assign is_start = (in_command == brl_pkg::CMD_START);
   assign emit     = accept && (is_start || active_ff);

   // line setup
   always_comb begin
      dx      = brl_pkg::delta_type'({1'b0, in_x_end}) - brl_pkg::delta_type'({1'b0, in_x_start});
      dy      = brl_pkg::delta_type'({1'b0, in_y_end}) - brl_pkg::delta_type'({1'b0, in_y_start});
      st_adx  = dx[brl_pkg::COORD_BITS] ? brl_pkg::coord_type'(-dx) : brl_pkg::coord_type'(dx);
      st_ady  = dy[brl_pkg::COORD_BITS] ? brl_pkg::coord_type'(-dy) : brl_pkg::coord_type'(dy);
      st_xmaj = (st_ady <= st_adx);
      st_up   = (dx != '0) && (dy != '0) && (dx[brl_pkg::COORD_BITS] == dy[brl_pkg::COORD_BITS]);
      if (st_xmaj) begin
         st_err = brl_pkg::err_type'({st_ady, 1'b0}) - brl_pkg::err_type'(st_adx);
         st_neg = dx[brl_pkg::COORD_BITS];
      end else begin
         st_err = brl_pkg::err_type'({st_adx, 1'b0}) - brl_pkg::err_type'(st_ady);
         st_neg = dy[brl_pkg::COORD_BITS];
      end
      // walk always starts at the endpoint with the smaller major coordinate
      st_col = st_neg ? in_x_end : in_x_start;
      st_row = st_neg ? in_y_end : in_y_start;
      if (st_xmaj) begin
         st_mend = st_neg ? in_x_start : in_x_end;
      end else begin
         st_mend = st_neg ? in_y_start : in_y_end;
      end
   end

   // one step along the current line
   always_comb begin
      two_adx = brl_pkg::err_type'({adx_ff, 1'b0});
      two_ady = brl_pkg::err_type'({ady_ff, 1'b0});
      sp_col  = col_ff;
      sp_row  = row_ff;
      if (x_major_ff) begin
         sp_col = col_ff + 1'b1;
         if (err_ff < 0) begin
            sp_err = err_ff + two_ady;
         end else begin
            sp_row = minor_up_ff ? row_ff + 1'b1 : row_ff - 1'b1;
            sp_err = err_ff + (two_ady - two_adx);
         end
      end else begin
         sp_row = row_ff + 1'b1;
         if (err_ff <= 0) begin
            sp_err = err_ff + two_adx;
         end else begin
            sp_col = minor_up_ff ? col_ff + 1'b1 : col_ff - 1'b1;
            sp_err = err_ff + (two_adx - two_ady);
         end
      end
   end

   always_comb begin
      if (is_start) begin
         col_in       = st_col;
         row_in       = st_row;
         err_in       = st_err;
         major_end_in = st_mend;
         adx_in       = st_adx;
         ady_in       = st_ady;
         x_major_in   = st_xmaj;
         minor_up_in  = st_up;
      end else begin
         col_in       = sp_col;
         row_in       = sp_row;
         err_in       = sp_err;
         major_end_in = major_end_ff;
         adx_in       = adx_ff;
         ady_in       = ady_ff;
         x_major_in   = x_major_ff;
         minor_up_in  = minor_up_ff;
      end
      fin = ((x_major_in ? col_in : row_in) == major_end_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         major_end_ff <= '0;
         err_ff       <= '0;
         adx_ff       <= '0;
         ady_ff       <= '0;
         x_major_ff   <= 1'b0;
         minor_up_ff  <= 1'b0;
         active_ff    <= 1'b0;
         s1_valid_ff  <= 1'b0;
      end else begin
         if (emit) begin
            col_ff       <= col_in;
            row_ff       <= row_in;
            major_end_ff <= major_end_in;
            err_ff       <= err_in;
            adx_ff       <= adx_in;
            ady_ff       <= ady_in;
            x_major_ff   <= x_major_in;
            minor_up_ff  <= minor_up_in;
            active_ff    <= !fin;
         end
         if (in_ready) begin
            s1_valid_ff <= emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         s1_pixel_ff.x    <= col_in;
         s1_pixel_ff.y    <= row_in;
         s1_pixel_ff.last <= fin;
      end
   end

   assign out_valid = s1_valid_ff;
   assign out_pixel = s1_pixel_ff;

endmodule
`default_nettype wire

### sv/brl_pixel.sv
// Address multiply-add, outside test and result register.
`default_nettype none
module brl_pixel (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              in_valid,
   output logic                             in_ready,
   input  brl_pkg::pixel_type               in_pixel,
   input  wire [brl_pkg::DIM_BITS-1:0]      image_width,
   input  wire [brl_pkg::DIM_BITS-1:0]      image_height,
   input  wire [brl_pkg::COLOR_BITS-1:0]    draw_color,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output brl_pkg::rsp_data_type            rsp_tdata,
   output logic                             rsp_tuser,
   output logic                             rsp_tlast
);

   logic                              valid_ff;
   logic [brl_pkg::ADDR_BITS-1:0]     addr_in, addr_ff;
   brl_pkg::sum_type                  sum;
   logic                              outside_in, outside_ff;
   brl_pkg::coord_type                x_ff, y_ff;
   logic                              last_ff;
   logic [brl_pkg::COLOR_BITS-1:0]    color_ff;

   assign in_ready = !valid_ff || rsp_tready;

   always_comb begin
      sum = brl_pkg::sum_type'(in_pixel.x) +
            brl_pkg::sum_type'(image_width) * brl_pkg::sum_type'(in_pixel.y);
      addr_in = sum[brl_pkg::ADDR_BITS-1:0];
      outside_in = (brl_pkg::cmp_type'(in_pixel.x) >= brl_pkg::cmp_type'(image_width)) ||
                   (brl_pkg::cmp_type'(in_pixel.y) >= brl_pkg::cmp_type'(image_height));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         x_ff       <= in_pixel.x;
         y_ff       <= in_pixel.y;
         last_ff    <= in_pixel.last;
         addr_ff    <= addr_in;
         outside_ff <= outside_in;
         color_ff   <= draw_color;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = brl_pkg::rsp_data_type'({color_ff, addr_ff, y_ff, x_ff});
   assign rsp_tuser  = outside_ff;
   assign rsp_tlast  = last_ff;

endmodule
`default_nettype wire

### sv/bresenham_line_rasterizer_unit.sv
// Top level of the Bresenham line rasterizer: ports, control registers and the two stages.
// Each pixel passes the walker stage register, then the pixel stage register, before rsp.
// Throughput: one command word per cycle while rsp_tready is high; a start or an in-line
// step yields one pixel, a step with no line in progress yields none. The walker state
// loops back through the step logic. Reset (synchronous, active high) drops any line and
// empties both stages; control registers return to width 1600, height 900, color 0xFFC39F.
`default_nettype none
module bresenham_line_rasterizer_unit (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // x_start, y_start, x_end, y_end, zero pad
   input  wire [brl_pkg::REQ_DATA_BITS-1:0]     req_tdata,
   // command
   input  wire                                  req_tuser,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // pixel_x, pixel_y, pixel_address, pixel_color, zero pad
   output logic [brl_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   // outside
   output logic                                 rsp_tuser,
   output logic                                 rsp_tlast,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire [brl_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire [brl_pkg::COLOR_BITS-1:0]        csr_data
);

   localparam int CB = brl_pkg::COORD_BITS;

   logic [brl_pkg::DIM_BITS-1:0]   width_ff, height_ff;
   logic [brl_pkg::COLOR_BITS-1:0] color_ff;
   logic                           pix_valid, pix_ready;
   brl_pkg::pixel_type             pix;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= brl_pkg::WIDTH_RESET;
         height_ff <= brl_pkg::HEIGHT_RESET;
         color_ff  <= brl_pkg::COLOR_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            brl_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_data[brl_pkg::DIM_BITS-1:0];
            brl_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_data[brl_pkg::DIM_BITS-1:0];
            brl_pkg::CSR_DRAW_COLOR:   color_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   brl_walker u_walker (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_command (req_tuser),
      .in_x_start (req_tdata[CB-1:0]),
      .in_y_start (req_tdata[2*CB-1:CB]),
      .in_x_end   (req_tdata[3*CB-1:2*CB]),
      .in_y_end   (req_tdata[4*CB-1:3*CB]),
      .out_valid  (pix_valid),
      .out_ready  (pix_ready),
      .out_pixel  (pix)
   );

   brl_pixel u_pixel (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (pix_valid),
      .in_ready     (pix_ready),
      .in_pixel     (pix),
      .image_width  (width_ff),
      .image_height (height_ff),
      .draw_color   (color_ff),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast)
   );

endmodule
`default_nettype wire

### sim/tb_bresenham_line_rasterizer_unit.sv
// Self-checking testbench for the Bresenham line rasterizer: line walks, register settings, stalls.
module tb_bresenham_line_rasterizer_unit;
   import brl_pkg::*;

   localparam int Y_LSB       = COORD_BITS;
   localparam int ADDR_LSB    = 2 * COORD_BITS;
   localparam int COLOR_LSB   = ADDR_LSB + ADDR_BITS;
   localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 8;
   localparam int HOLD_CYCLES = 300;

   typedef struct {
      coord_type             x;
      coord_type             y;
      logic [ADDR_BITS-1:0]  addr;
      logic [COLOR_BITS-1:0] color;
      logic                  outside;
      logic                  last;
   } pixel_rec;

   // Line walker prediction plus the queue of pixels still owed by the block.
   class raster_scoreboard;
      logic [DIM_BITS-1:0]   width_reg;
      logic [DIM_BITS-1:0]   height_reg;
      logic [COLOR_BITS-1:0] color_reg;
      coord_type             col;
      coord_type             row;
      coord_type             major_end;
      int                    err;
      int                    adx;
      int                    ady;
      bit                    x_major;
      bit                    minor_up;
      bit                    line_on;
      pixel_rec              expected_pixels[$];
      int                    mismatches;
      int                    pixels_predicted;
      int                    pixels_checked;
      int                    lines_started;

      function new();
         width_reg        = WIDTH_RESET;
         height_reg       = HEIGHT_RESET;
         color_reg        = COLOR_RESET;
         col              = '0;
         row              = '0;
         major_end        = '0;
         err              = 0;
         adx              = 0;
         ady              = 0;
         x_major          = 1'b0;
         minor_up         = 1'b0;
         line_on          = 1'b0;
         mismatches       = 0;
         pixels_predicted = 0;
         pixels_checked   = 0;
         lines_started    = 0;
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction

      function void write_reg(logic [CSR_INDEX_BITS-1:0] reg_index, logic [COLOR_BITS-1:0] value);
         case (reg_index)
            CSR_IMAGE_WIDTH: width_reg = value[DIM_BITS-1:0];
            CSR_IMAGE_HEIGHT: height_reg = value[DIM_BITS-1:0];
            CSR_DRAW_COLOR: color_reg = value;
            default: ;
         endcase
      endfunction

      function void note_command(logic cmd, req_data_type data);
         coord_type        xs;
         coord_type        ys;
         coord_type        xe;
         coord_type        ye;
         coord_type        along;
         int               dx;
         int               dy;
         logic [63:0]      addr;
         pixel_rec         px;
         xs = data[0 +: COORD_BITS];
         ys = data[COORD_BITS +: COORD_BITS];
         xe = data[2 * COORD_BITS +: COORD_BITS];
         ye = data[3 * COORD_BITS +: COORD_BITS];
         if (cmd == CMD_START) begin
            dx = int'(xe) - int'(xs);
            dy = int'(ye) - int'(ys);
            adx = (dx < 0) ? -dx : dx;
            ady = (dy < 0) ? -dy : dy;
            minor_up = (dx < 0 && dy < 0) || (dx > 0 && dy > 0);
            x_major = (ady <= adx);
            // walk always starts at the endpoint with the smaller major coordinate
            if (x_major) begin
               err = 2 * ady - adx;
               if (dx >= 0) begin
                  col = xs; row = ys; major_end = xe;
               end else begin
                  col = xe; row = ye; major_end = xs;
               end
            end else begin
               err = 2 * adx - ady;
               if (dy >= 0) begin
                  col = xs; row = ys; major_end = ye;
               end else begin
                  col = xe; row = ye; major_end = ys;
               end
            end
            line_on = 1'b1;
            lines_started++;
         end else begin
            if (!line_on)
               return;
            if (x_major) begin
               col = col + 1'b1;
               if (err < 0) begin
                  err += 2 * ady;
               end else begin
                  row = minor_up ? row + 1'b1 : row - 1'b1;
                  err += 2 * (ady - adx);
               end
            end else begin
               row = row + 1'b1;
               // y-major keeps the minor axis on a zero error term
               if (err <= 0) begin
                  err += 2 * adx;
               end else begin
                  col = minor_up ? col + 1'b1 : col - 1'b1;
                  err += 2 * (adx - ady);
               end
            end
         end
         along = x_major ? col : row;
         addr = 64'(col) + 64'(width_reg) * 64'(row);
         px.x = col;
         px.y = row;
         px.addr = addr[ADDR_BITS-1:0];
         px.color = color_reg;
         px.outside = (col >= width_reg) || (row >= height_reg);
         px.last = (along == major_end);
         if (px.last)
            line_on = 1'b0;
         expected_pixels.push_back(px);
         pixels_predicted++;
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
            mismatches++;
         end
      endfunction

      function void check_pixel(rsp_data_type data, logic outside, logic last);
         pixel_rec want;
         if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected pixel, expected none, actual tdata %h outside %b last %b",
                     $time, data, outside, last);
            mismatches++;
            return;
         end
         want = expected_pixels.pop_front();
         pixels_checked++;
         compare_field("pixel_x", want.x, data[0 +: COORD_BITS]);
         compare_field("pixel_y", want.y, data[Y_LSB +: COORD_BITS]);
         compare_field("pixel_address", want.addr, data[ADDR_LSB +: ADDR_BITS]);
         compare_field("pixel_color", want.color, data[COLOR_LSB +: COLOR_BITS]);
         compare_field("outside", want.outside, outside);
         compare_field("last", want.last, last);
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid;
   logic                      req_tready;
   req_data_type              req_tdata;
   logic                      req_tuser;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   rsp_data_type              rsp_tdata;
   logic                      rsp_tuser;
   logic                      rsp_tlast;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [COLOR_BITS-1:0]     csr_data;

   raster_scoreboard sb = new();
   bit gaps_on   = 1'b1;
   bit stall_rsp = 1'b0;
   int words_sent = 0;
   int settings_used = 1;
   int cycles = 0;

   bresenham_line_rasterizer_unit dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d pixels outstanding", $time, sb.pending());
         $display("tb_bresenham_line_rasterizer_unit: FAIL");
         $finish;
      end
   end

   // Handshake monitors; values are the ones present before the edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_command(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready)
            sb.check_pixel(rsp_tdata, rsp_tuser, rsp_tlast);
         if (csr_valid && csr_ready)
            sb.write_reg(csr_index, csr_data);
      end
   end

   // Pixel receiver: random stall bursts, plus one long hold-off on request.
   initial begin
      rsp_tready <= 1'b0;
      while (reset)
         @(posedge clock);
      forever begin
         if (stall_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            stall_rsp = 1'b0;
         end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   task automatic send_word(logic cmd, coord_type xs, coord_type ys, coord_type xe, coord_type ye);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= req_data_type'({ye, xe, ys, xs});
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      words_sent++;
   endtask

   // Start word followed by a given number of step words with junk coordinates.
   task automatic walk_line(int xs, int ys, int xe, int ye, int steps);
      send_word(CMD_START, coord_type'(xs), coord_type'(ys), coord_type'(xe), coord_type'(ye));
      repeat (steps)
         send_word(CMD_STEP, coord_type'($urandom), coord_type'($urandom),
                   coord_type'($urandom), coord_type'($urandom));
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
      // ignored steps leave nothing to wait on; let the pipe empty
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] reg_index, logic [COLOR_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= reg_index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
   endtask

   task automatic set_config(int w, int h, logic [COLOR_BITS-1:0] color);
      wait_idle();
      // junk above the 12 register bits must be dropped
      write_csr(CSR_IMAGE_WIDTH, {12'($urandom), 12'(w)});
      write_csr(CSR_IMAGE_HEIGHT, {12'($urandom), 12'(h)});
      write_csr(CSR_DRAW_COLOR, color);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic random_line();
      int xs, ys, xe, ye, span, dx, dy, adx, ady, pixels, steps, shape;
      span = ($urandom_range(0, 24) == 0) ? 180 : 10;
      xs = $urandom_range(0, COORD_MAX);
      ys = $urandom_range(0, COORD_MAX);
      dx = $urandom_range(0, span);
      dy = $urandom_range(0, span);
      shape = $urandom_range(0, 9);
      if (shape == 0)
         dx = 0;
      else if (shape == 1)
         dy = 0;
      if ($urandom_range(0, 1))
         dx = -dx;
      if ($urandom_range(0, 1))
         dy = -dy;
      xe = xs + dx;
      if (xe < 0 || xe > COORD_MAX)
         xe = xs - dx;
      ye = ys + dy;
      if (ye < 0 || ye > COORD_MAX)
         ye = ys - dy;
      adx = (xe > xs) ? xe - xs : xs - xe;
      ady = (ye > ys) ? ye - ys : ys - ye;
      pixels = ((adx > ady) ? adx : ady) + 1;
      case ($urandom_range(0, 9))
         0: steps = $urandom_range(0, pixels - 1);          // dropped by the next start
         1: steps = pixels - 1 + $urandom_range(1, 3);      // steps past the end
         default: steps = pixels - 1;
      endcase
      walk_line(xs, ys, xe, ye, steps);
   endtask

   task automatic random_lines(int pixel_goal);
      int goal;
      goal = sb.pixels_predicted + pixel_goal;
      while (sb.pixels_predicted < goal)
         random_line();
   endtask

   initial begin
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= CMD_START;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_IMAGE_WIDTH;
      csr_data   <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed lines under the reset register values
      send_word(CMD_STEP, coord_type'(COORD_MAX), coord_type'(COORD_MAX),
                coord_type'(COORD_MAX), coord_type'(COORD_MAX));
      walk_line(0, 0, 0, 0, 1);
      walk_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0);
      walk_line(COORD_MAX, 0, COORD_MAX - 3, 0, 4);
      walk_line(0, COORD_MAX, 0, COORD_MAX - 2, 2);
      walk_line(3, 1, 5, 6, 5);
      walk_line(10, 10, 7, 13, 3);
      walk_line(0, COORD_MAX, COORD_MAX, 0, 2);
      random_lines(80);

      set_config(1, 1, 24'h000000);
      random_lines(80);

      set_config(2048, 2048, 24'hFFFFFF);
      stall_rsp = 1'b1;
      walk_line(100, 100, 300, 160, 200);
      random_lines(60);

      set_config(0, 0, 24'($urandom));
      random_lines(80);

      set_config(4095, 4095, 24'($urandom));
      random_lines(80);

      set_config($urandom_range(1, 2048), $urandom_range(1, 2048), 24'($urandom));
      random_lines(80);

      gaps_on = 1'b0;
      set_config($urandom_range(1, 2048), $urandom_range(1, 2048), 24'($urandom));
      random_lines(80);

      wait_idle();
      $display("covered %0d lines over %0d register settings:",
               sb.lines_started, settings_used);
      $display("%0d command words, %0d pixels checked", words_sent, sb.pixels_checked);
      $display("%0d mismatches", sb.mismatches);
      if (sb.mismatches == 0)
         $display("tb_bresenham_line_rasterizer_unit: PASS");
      else
         $display("tb_bresenham_line_rasterizer_unit: FAIL");
      $finish;
   end
endmodule
